// ----- rtl/metbl_pkg.sv -----
package metbl_pkg;

  localparam int SLOTS_DEF     = 256;
  localparam int NODE_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_FIND_ADD = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_ADD_AT   = 3'd2,
    MODE_ERASE    = 3'd3,
    MODE_SET_FACE = 3'd4,
    MODE_COMMON   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TWO_FACES = 3'd4,
    ST_NO_COMMON = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CHK,
    S_ADD,
    S_IDX_RD,
    S_IDX_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_CMN_RD,
    S_CMN_CHK,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/mesh_edge_table_engine_unit.sv -----
// Channel | Ports                      | Beat contents (low bit up)
// in      | in_tvalid/in_tready/tdata  | mode[2:0] node_a[18:3] node_b[34:19]
//         |                            | index_a[42:35] index_b[50:43] face[66:51]
// out     | out_tvalid/out_tready/tdata| slot[7:0] shared_node[23:8] created[24]
//         |                            | status[27:25] slots_used[36:28] edges_valid[45:37]
// One beat at a time through a sequencer around the slot RAMs (one read port).
// find_or_add searches the allocated slots in turn and adds if none holds both nodes; an add
// that reuses a freed slot shifts the free list; add_at on a freed slot first finds it there;
// erase and set_face read, then write the slot; common_node reads both; a bad index reads nothing.
// rst_n clears counts and occupancy; RAMs keep their contents.
// in_tready is low while a beat is in work or its result is held.
module mesh_edge_table_engine_unit #(
  parameter int SLOTS     = metbl_pkg::SLOTS_DEF,
  parameter int NODE_BITS = metbl_pkg::NODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode, node_a, node_b, index_a, index_b, face
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // slot, shared_node, created, status, slots_used, edges_valid
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = 17;
  localparam logic [FW-1:0] FACE_NONE = '1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  metbl_pkg::state_t state_r, state_nxt;

  logic [2:0]  mode_r;
  logic [NODE_BITS-1:0] na_r, nb_r;
  logic [7:0]  ia_r, ib_r;
  logic [15:0] face_r;
  logic [CW-1:0] alloc_r, valid_r, freec_r, idx_r;
  logic [SLOTS-1:0] occ_r;
  logic [AW-1:0] tgt_r;
  logic [NODE_BITS-1:0] bn1_r, bn2_r;
  logic        cmn_second_r;

  logic [7:0]  slot_r;
  logic [15:0] shared_r;
  logic        created_r;
  logic [2:0]  status_r;

  // memory ports
  logic [AW-1:0] nd_raddr, fc_raddr, fl_raddr, nd_waddr, fl_waddr;
  logic nd_we, f1_we, f2_we, fl_we;
  logic [NODE_BITS-1:0] n1_wd, n2_wd, n1_rd, n2_rd;
  logic [FW-1:0] f1_wd, f2_wd, f1_rd, f2_rd;
  logic [AW-1:0] fl_wd, fl_rd;

  metbl_ram #(.WIDTH(NODE_BITS), .DEPTH(SLOTS)) u_n1 (.clk(clk), .we(nd_we),
    .waddr(nd_waddr), .wdata(n1_wd), .raddr(nd_raddr), .rdata(n1_rd));
  metbl_ram #(.WIDTH(NODE_BITS), .DEPTH(SLOTS)) u_n2 (.clk(clk), .we(nd_we),
    .waddr(nd_waddr), .wdata(n2_wd), .raddr(nd_raddr), .rdata(n2_rd));
  metbl_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_f1 (.clk(clk), .we(f1_we),
    .waddr(nd_waddr), .wdata(f1_wd), .raddr(fc_raddr), .rdata(f1_rd));
  metbl_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_f2 (.clk(clk), .we(f2_we),
    .waddr(nd_waddr), .wdata(f2_wd), .raddr(fc_raddr), .rdata(f2_rd));
  metbl_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_fl (.clk(clk), .we(fl_we),
    .waddr(fl_waddr), .wdata(fl_wd), .raddr(fl_raddr), .rdata(fl_rd));

  logic in_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == metbl_pkg::S_IDLE);
  assign out_tvalid = (state_r == metbl_pkg::S_DONE);
  assign out_tdata = {2'b0, 9'(valid_r), 9'(alloc_r), status_r, created_r, shared_r, slot_r};

  // index checks (index fields are 8 bits; compare in a common width)
  localparam int XW = (CW > 9) ? CW : 9;
  logic ia_bad, ib_bad, match, holds_b1, holds_b2, full;
  assign ia_bad = (XW'(ia_r) >= XW'(alloc_r));
  assign ib_bad = (XW'(ib_r) >= XW'(alloc_r));
  assign match  = (na_r == n1_rd || na_r == n2_rd) && (nb_r == n1_rd || nb_r == n2_rd);
  assign holds_b1 = (bn1_r == n1_rd || bn1_r == n2_rd);
  assign holds_b2 = (bn2_r == n1_rd || bn2_r == n2_rd);
  assign full = (freec_r == '0) && (alloc_r == SLOTS_C);

  logic [AW-1:0] ia_s, ib_s, idx_s;
  assign ia_s  = AW'(ia_r);
  assign ib_s  = AW'(ib_r);
  assign idx_s = idx_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      metbl_pkg::S_IDLE:   if (in_fire) state_nxt = metbl_pkg::S_DECODE;
      metbl_pkg::S_DECODE: begin
        unique case (mode_r)
          metbl_pkg::MODE_FIND_ADD: state_nxt = (alloc_r == '0) ? metbl_pkg::S_ADD
                                                                 : metbl_pkg::S_FIND_RD;
          metbl_pkg::MODE_ADD: state_nxt = metbl_pkg::S_ADD;
          metbl_pkg::MODE_ADD_AT, metbl_pkg::MODE_ERASE, metbl_pkg::MODE_SET_FACE:
            state_nxt = ia_bad ? metbl_pkg::S_DONE : metbl_pkg::S_IDX_RD;
          metbl_pkg::MODE_COMMON:
            state_nxt = (ia_bad || ib_bad) ? metbl_pkg::S_DONE
                      : (!occ_r[ia_s] || !occ_r[ib_s]) ? metbl_pkg::S_DONE
                      : metbl_pkg::S_CMN_RD;
          default: state_nxt = metbl_pkg::S_DONE;
        endcase
      end
      metbl_pkg::S_FIND_RD:  state_nxt = metbl_pkg::S_FIND_CHK;
      metbl_pkg::S_FIND_CHK: begin
        if (occ_r[idx_s] && match) state_nxt = metbl_pkg::S_DONE;
        else if (idx_r + CW'(1) >= alloc_r) state_nxt = metbl_pkg::S_ADD;
        else state_nxt = metbl_pkg::S_FIND_RD;
      end
      metbl_pkg::S_ADD: begin
        if (full) state_nxt = metbl_pkg::S_DONE;
        else if (freec_r != '0) state_nxt = metbl_pkg::S_SHIFT_RD;
        else state_nxt = metbl_pkg::S_WRITE;
      end
      metbl_pkg::S_IDX_RD:  state_nxt = metbl_pkg::S_IDX_CHK;
      metbl_pkg::S_IDX_CHK: begin
        if (mode_r == metbl_pkg::MODE_ADD_AT)
          state_nxt = (!occ_r[ia_s] && freec_r != '0) ? metbl_pkg::S_FREE_RD
                                                      : metbl_pkg::S_WRITE;
        else state_nxt = metbl_pkg::S_WRITE;
      end
      metbl_pkg::S_FREE_RD:  state_nxt = metbl_pkg::S_FREE_CHK;
      metbl_pkg::S_FREE_CHK: begin
        if (fl_rd == ia_s) state_nxt = metbl_pkg::S_SHIFT_RD;
        else if (idx_r + CW'(1) >= freec_r) state_nxt = metbl_pkg::S_WRITE;
        else state_nxt = metbl_pkg::S_FREE_RD;
      end
      metbl_pkg::S_SHIFT_RD: state_nxt = (idx_r + CW'(1) >= freec_r) ? metbl_pkg::S_WRITE
                                                                     : metbl_pkg::S_SHIFT_WR;
      metbl_pkg::S_SHIFT_WR: state_nxt = metbl_pkg::S_SHIFT_RD;
      metbl_pkg::S_CMN_RD:  state_nxt = metbl_pkg::S_CMN_CHK;
      metbl_pkg::S_CMN_CHK: state_nxt = cmn_second_r ? metbl_pkg::S_DONE : metbl_pkg::S_CMN_RD;
      metbl_pkg::S_WRITE:   state_nxt = metbl_pkg::S_DONE;
      metbl_pkg::S_DONE:    if (out_tready) state_nxt = metbl_pkg::S_IDLE;
      default: state_nxt = metbl_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    nd_raddr = idx_s;
    fc_raddr = ia_s;
    fl_raddr = idx_s;
    nd_we = 1'b0; f1_we = 1'b0; f2_we = 1'b0; fl_we = 1'b0;
    nd_waddr = tgt_r;
    n1_wd = na_r; n2_wd = nb_r;
    f1_wd = FACE_NONE; f2_wd = FACE_NONE;
    fl_waddr = idx_s;
    fl_wd = fl_rd;
    unique case (state_r)
      // fetch the free-list head for the add that follows
      metbl_pkg::S_ADD: fl_raddr = '0;
      metbl_pkg::S_IDX_RD: nd_raddr = ia_s;
      metbl_pkg::S_CMN_RD: nd_raddr = cmn_second_r ? ia_s : ib_s;
      metbl_pkg::S_SHIFT_RD: fl_raddr = AW'(idx_r + CW'(1));
      metbl_pkg::S_SHIFT_WR: fl_we = 1'b1;
      metbl_pkg::S_WRITE: begin
        // hold the RAMs on an error status
        if (status_r == metbl_pkg::ST_OK) begin
          unique case (mode_r)
            metbl_pkg::MODE_ERASE: begin
              fl_we = (freec_r < SLOTS_C);
              fl_waddr = freec_r[AW-1:0];
              fl_wd = ia_s;
            end
            metbl_pkg::MODE_SET_FACE: begin
              f1_wd = FW'(face_r); f2_wd = FW'(face_r);
              f1_we = (f1_rd == FACE_NONE);
              f2_we = (f1_rd != FACE_NONE) && (f2_rd == FACE_NONE);
            end
            default: begin
              nd_we = 1'b1; f1_we = 1'b1; f2_we = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= metbl_pkg::S_IDLE;
      alloc_r <= '0;
      valid_r <= '0;
      freec_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        metbl_pkg::S_IDLE: if (in_fire) begin
          mode_r <= in_tdata[2:0];
          na_r   <= NODE_BITS'(in_tdata[18:3]);
          nb_r   <= NODE_BITS'(in_tdata[34:19]);
          ia_r   <= in_tdata[42:35];
          ib_r   <= in_tdata[50:43];
          face_r <= in_tdata[66:51];
          slot_r <= '0; shared_r <= '0; created_r <= 1'b0;
          status_r <= metbl_pkg::ST_OK;
          idx_r <= '0;
          cmn_second_r <= 1'b0;
        end
        metbl_pkg::S_DECODE: begin
          if (mode_r == metbl_pkg::MODE_ADD_AT || mode_r == metbl_pkg::MODE_ERASE ||
              mode_r == metbl_pkg::MODE_SET_FACE || mode_r == metbl_pkg::MODE_COMMON) begin
            slot_r <= ia_r;
            tgt_r  <= ia_s;
            if (ia_bad || (mode_r == metbl_pkg::MODE_COMMON && ib_bad))
              status_r <= metbl_pkg::ST_BAD_INDEX;
            else if (mode_r == metbl_pkg::MODE_COMMON && (!occ_r[ia_s] || !occ_r[ib_s]))
              status_r <= metbl_pkg::ST_EMPTY;
          end
        end
        metbl_pkg::S_FIND_CHK: begin
          if (occ_r[idx_s] && match) slot_r <= 8'(idx_r);
          else idx_r <= idx_r + CW'(1);
        end
        metbl_pkg::S_ADD: begin
          idx_r <= '0;
          if (full) status_r <= metbl_pkg::ST_FULL;
          else begin
            created_r <= (mode_r == metbl_pkg::MODE_FIND_ADD);
            valid_r <= valid_r + CW'(1);
            if (freec_r == '0) begin
              tgt_r  <= alloc_r[AW-1:0];
              slot_r <= 8'(alloc_r);
              alloc_r <= alloc_r + CW'(1);
            end
          end
        end
        metbl_pkg::S_IDX_CHK: begin
          idx_r <= '0;
          if (mode_r == metbl_pkg::MODE_ERASE || mode_r == metbl_pkg::MODE_SET_FACE) begin
            if (!occ_r[ia_s]) status_r <= metbl_pkg::ST_EMPTY;
            else if (mode_r == metbl_pkg::MODE_SET_FACE && f1_rd != FACE_NONE &&
                     f2_rd != FACE_NONE) status_r <= metbl_pkg::ST_TWO_FACES;
          end
          if (mode_r == metbl_pkg::MODE_ADD_AT && !occ_r[ia_s]) valid_r <= valid_r + CW'(1);
        end
        metbl_pkg::S_FREE_CHK: if (fl_rd != ia_s) idx_r <= idx_r + CW'(1);
        metbl_pkg::S_SHIFT_RD: begin
          // the head entry names the slot for an add
          if (idx_r == '0 && mode_r != metbl_pkg::MODE_ADD_AT) begin
            tgt_r  <= fl_rd;
            slot_r <= 8'(fl_rd);
          end
          if (idx_r + CW'(1) >= freec_r) freec_r <= freec_r - CW'(1);
        end
        metbl_pkg::S_SHIFT_WR: idx_r <= idx_r + CW'(1);
        metbl_pkg::S_CMN_CHK: begin
          if (!cmn_second_r) begin
            bn1_r <= n1_rd; bn2_r <= n2_rd;
            cmn_second_r <= 1'b1;
          end else if (holds_b1) shared_r <= 16'(bn1_r);
          else if (holds_b2) shared_r <= 16'(bn2_r);
          else status_r <= metbl_pkg::ST_NO_COMMON;
        end
        metbl_pkg::S_WRITE: begin
          if (status_r == metbl_pkg::ST_OK) begin
            if (mode_r == metbl_pkg::MODE_ERASE) begin
              occ_r[tgt_r] <= 1'b0;
              valid_r <= valid_r - CW'(1);
              if (freec_r < SLOTS_C) freec_r <= freec_r + CW'(1);
            end else if (mode_r != metbl_pkg::MODE_SET_FACE) begin
              occ_r[tgt_r] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  property p_busy;
    @(posedge clk) disable iff (!rst_n) in_fire |=> !in_tready;
  endproperty
  a_busy: assert property (p_busy) else $error("accepted while busy");

  a_valid_le_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r <= alloc_r) else $error("valid count above allocation");

  a_free_le: assert property (@(posedge clk) disable iff (!rst_n)
    freec_r <= alloc_r) else $error("free count above allocation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule

// ----- rtl/metbl_ram.sv -----
module metbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int NSLOT = 256;
  localparam logic [16:0] NO_FACE = 17'h1FFFF;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int RANDOM_BEATS = 1600;

  // mode sits in the lowest bits
  typedef struct packed {
    logic [15:0] face;
    logic [7:0]  index_b;
    logic [7:0]  index_a;
    logic [15:0] node_b;
    logic [15:0] node_a;
    logic [2:0]  mode;
  } edge_op_t;

  // slot sits in the lowest bits
  typedef struct packed {
    logic [8:0]  edges_valid;
    logic [8:0]  slots_used;
    logic [2:0]  status;
    logic        created;
    logic [15:0] shared_node;
    logic [7:0]  slot;
  } edge_res_t;

  typedef struct {
    edge_op_t  op;
    bit        typed;
    edge_res_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  mesh_edge_table_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // table mirror
  logic [15:0] tbl_node0 [NSLOT];
  logic [15:0] tbl_node1 [NSLOT];
  logic [16:0] tbl_face0 [NSLOT];
  logic [16:0] tbl_face1 [NSLOT];
  bit          tbl_occ   [NSLOT];
  int          free_fifo[$];
  int          alloc_cnt = 0;
  int          live_cnt = 0;

  edge_res_t   pending_res[$];
  bit          typed_flag_q[$];
  edge_res_t   typed_res_q[$];
  int          errors = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;

  function automatic bit holds_node(int s, logic [15:0] n);
    return n == tbl_node0[s] || n == tbl_node1[s];
  endfunction

  function automatic void place(int s, logic [15:0] na, logic [15:0] nb);
    tbl_node0[s] = na;
    tbl_node1[s] = nb;
    tbl_face0[s] = NO_FACE;
    tbl_face1[s] = NO_FACE;
    tbl_occ[s] = 1'b1;
  endfunction

  // returns -1 when the table is full
  function automatic int take_slot(logic [15:0] na, logic [15:0] nb);
    int s;
    if (free_fifo.size() > 0) begin
      s = free_fifo.pop_front();
    end else if (alloc_cnt < NSLOT) begin
      s = alloc_cnt;
      alloc_cnt++;
    end else begin
      return -1;
    end
    place(s, na, nb);
    live_cnt++;
    return s;
  endfunction

  function automatic edge_res_t apply_edge_op(edge_op_t op);
    edge_res_t r;
    int hit;
    int ia;
    int ib;
    r = '0;
    ia = op.index_a;
    ib = op.index_b;
    case (op.mode)
      metbl_pkg::MODE_FIND_ADD: begin
        hit = -1;
        for (int i = 0; i < alloc_cnt; i++) begin
          if (tbl_occ[i] && holds_node(i, op.node_a) && holds_node(i, op.node_b)) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          r.slot = 8'(hit);
        end else begin
          hit = take_slot(op.node_a, op.node_b);
          if (hit < 0) r.status = metbl_pkg::ST_FULL;
          else begin
            r.slot = 8'(hit);
            r.created = 1'b1;
          end
        end
      end
      metbl_pkg::MODE_ADD: begin
        hit = take_slot(op.node_a, op.node_b);
        if (hit < 0) r.status = metbl_pkg::ST_FULL;
        else r.slot = 8'(hit);
      end
      metbl_pkg::MODE_ADD_AT: begin
        r.slot = 8'(ia);
        if (ia >= alloc_cnt) r.status = metbl_pkg::ST_BAD_INDEX;
        else begin
          if (!tbl_occ[ia]) begin
            for (int k = 0; k < free_fifo.size(); k++) begin
              if (free_fifo[k] == ia) begin
                free_fifo.delete(k);
                break;
              end
            end
            live_cnt++;
          end
          place(ia, op.node_a, op.node_b);
        end
      end
      metbl_pkg::MODE_ERASE: begin
        r.slot = 8'(ia);
        if (ia >= alloc_cnt) r.status = metbl_pkg::ST_BAD_INDEX;
        else if (!tbl_occ[ia]) r.status = metbl_pkg::ST_EMPTY;
        else begin
          tbl_occ[ia] = 1'b0;
          free_fifo = {free_fifo, ia};
          live_cnt--;
        end
      end
      metbl_pkg::MODE_SET_FACE: begin
        r.slot = 8'(ia);
        if (ia >= alloc_cnt) r.status = metbl_pkg::ST_BAD_INDEX;
        else if (!tbl_occ[ia]) r.status = metbl_pkg::ST_EMPTY;
        else if (tbl_face0[ia] == NO_FACE) tbl_face0[ia] = {1'b0, op.face};
        else if (tbl_face1[ia] == NO_FACE) tbl_face1[ia] = {1'b0, op.face};
        else r.status = metbl_pkg::ST_TWO_FACES;
      end
      metbl_pkg::MODE_COMMON: begin
        r.slot = 8'(ia);
        if (ia >= alloc_cnt || ib >= alloc_cnt) r.status = metbl_pkg::ST_BAD_INDEX;
        else if (!tbl_occ[ia] || !tbl_occ[ib]) r.status = metbl_pkg::ST_EMPTY;
        else if (holds_node(ia, tbl_node0[ib])) r.shared_node = tbl_node0[ib];
        else if (holds_node(ia, tbl_node1[ib])) r.shared_node = tbl_node1[ib];
        else r.status = metbl_pkg::ST_NO_COMMON;
      end
      default: ;
    endcase
    r.slots_used = 9'(alloc_cnt);
    r.edges_valid = 9'(live_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    edge_op_t  op;
    edge_res_t got;
    edge_res_t want;
    edge_res_t pred;
    if (rst_n && in_tvalid && in_tready) begin
      op = in_tdata[66:0];
      pred = apply_edge_op(op);
      if (typed_flag_q.pop_front()) pred = typed_res_q.pop_front();
      else void'(typed_res_q.pop_front());
      pending_res = {pending_res, pred};
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[45:0];
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_res.pop_front();
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.shared_node != want.shared_node)
          report_mismatch("shared_node", got.shared_node, want.shared_node);
        if (got.created != want.created) report_mismatch("created", got.created, want.created);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.slots_used != want.slots_used)
          report_mismatch("slots_used", got.slots_used, want.slots_used);
        if (got.edges_valid != want.edges_valid)
          report_mismatch("edges_valid", got.edges_valid, want.edges_valid);
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // called and returning at a falling edge; in_tready is stable until the next rising edge
  task automatic send_beat(edge_op_t op, bit typed, edge_res_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    typed_flag_q = {typed_flag_q, typed};
    typed_res_q = {typed_res_q, want};
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, op};
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_node();
    if ($urandom_range(99) < 80) return 16'($urandom_range(31));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(99) < 12 || alloc_cnt == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(alloc_cnt - 1));
  endfunction

  function automatic edge_op_t random_op();
    edge_op_t op;
    int roll;
    op.node_a = pick_node();
    op.node_b = pick_node();
    op.index_a = pick_index();
    op.index_b = pick_index();
    op.face = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 30) op.mode = metbl_pkg::MODE_ADD;
    else if (roll < 50) op.mode = metbl_pkg::MODE_FIND_ADD;
    else if (roll < 65) op.mode = metbl_pkg::MODE_ERASE;
    else if (roll < 75) begin
      op.mode = metbl_pkg::MODE_ADD_AT;
      // aim at freed slots to exercise free-list removal
      if (free_fifo.size() > 0 && $urandom_range(1))
        op.index_a = 8'(free_fifo[$urandom_range(free_fifo.size() - 1)]);
    end
    else if (roll < 90) op.mode = metbl_pkg::MODE_SET_FACE;
    else if (roll < 98) op.mode = metbl_pkg::MODE_COMMON;
    else op.mode = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
    return op;
  endfunction

  function automatic stim_row_t mk(logic [2:0] m, int na, int nb, int ia, int ib, int f,
                                   bit typed = 0, int slot = 0, int st = 0,
                                   int used = 0, int live = 0);
    stim_row_t row;
    row.op = '{mode: m, node_a: na[15:0], node_b: nb[15:0], index_a: ia[7:0],
               index_b: ib[7:0], face: f[15:0]};
    row.typed = typed;
    row.want = '{slot: slot[7:0], shared_node: 16'd0, created: 1'b0, status: st[2:0],
                 slots_used: used[8:0], edges_valid: live[8:0]};
    return row;
  endfunction

  stim_row_t directed[$];

  initial begin
    edge_res_t none;
    none = '0;
    directed = '{
      mk(metbl_pkg::MODE_ERASE,    0, 0, 0, 0, 0, 1, 0, metbl_pkg::ST_BAD_INDEX, 0, 0),
      mk(metbl_pkg::MODE_SET_FACE, 0, 0, 255, 0, 0, 1, 255, metbl_pkg::ST_BAD_INDEX, 0, 0),
      mk(metbl_pkg::MODE_COMMON,   0, 0, 0, 255, 0, 1, 0, metbl_pkg::ST_BAD_INDEX, 0, 0),
      mk(MODE_SPARE6, 'hFFFF, 'hFFFF, 255, 255, 'hFFFF, 1, 0, metbl_pkg::ST_OK, 0, 0),
      mk(MODE_SPARE7,   0, 0, 0, 0, 0, 1, 0, metbl_pkg::ST_OK, 0, 0),
      mk(metbl_pkg::MODE_ADD, 'hFFFF, 0, 0, 0, 0, 1, 0, metbl_pkg::ST_OK, 1, 1),
      mk(metbl_pkg::MODE_FIND_ADD, 0, 'hFFFF, 0, 0, 0),
      mk(metbl_pkg::MODE_FIND_ADD, 1, 2, 0, 0, 0),
      mk(metbl_pkg::MODE_FIND_ADD, 7, 7, 0, 0, 0),
      mk(metbl_pkg::MODE_SET_FACE, 0, 0, 0, 0, 'hFFFF),
      mk(metbl_pkg::MODE_SET_FACE, 0, 0, 0, 0, 0),
      mk(metbl_pkg::MODE_SET_FACE, 0, 0, 0, 0, 'h1234),
      mk(metbl_pkg::MODE_COMMON,   0, 0, 0, 1, 0),
      mk(metbl_pkg::MODE_ADD,      2, 3, 0, 0, 0),
      mk(metbl_pkg::MODE_COMMON,   0, 0, 1, 3, 0),
      mk(metbl_pkg::MODE_COMMON,   0, 0, 3, 1, 0),
      mk(metbl_pkg::MODE_ERASE,    0, 0, 1, 0, 0),
      mk(metbl_pkg::MODE_ERASE,    0, 0, 1, 0, 0),
      mk(metbl_pkg::MODE_SET_FACE, 0, 0, 1, 0, 5),
      mk(metbl_pkg::MODE_COMMON,   0, 0, 1, 0, 0),
      mk(metbl_pkg::MODE_ERASE,    0, 0, 3, 0, 0),
      mk(metbl_pkg::MODE_ADD_AT, 9, 9, 255, 0, 0),
      mk(metbl_pkg::MODE_ADD_AT, 4, 5, 1, 0, 0),
      mk(metbl_pkg::MODE_ADD_AT, 'hABCD, 'h5432, 0, 0, 0),
      mk(metbl_pkg::MODE_ADD,      6, 8, 0, 0, 0)
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[k]) send_beat(directed[k].op, directed[k].typed, directed[k].want);
    for (int ph = 0; ph < 4; ph++) begin
      in_tvalid <= 1'b0;
      // hold off until the block has drained
      if (ph == 2) while (pending_res.size() != 0) @(negedge clk);
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 50; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 50; end
        default: begin in_idle_pct = 12; out_stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_BEATS / 4; n++) send_beat(random_op(), 1'b0, none);
    end
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- mesh_edge_table_engine_unit.f -----
rtl/metbl_pkg.sv
rtl/metbl_ram.sv
rtl/mesh_edge_table_engine_unit.sv
verif/tb_top.sv
